[hw/rtl/jsu_pkg.sv]
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MAX_RES = 8;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        M_PLAIN  = 3'd0,
        M_ESC    = 3'd1,
        M_HEX    = 3'd2,
        M_HIWAIT = 3'd3,
        M_HIESC  = 3'd4,
        M_HIHEX  = 3'd5
    } jsu_mode_t;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CTL_BS   = 8'h08;
    localparam logic [7:0] CTL_FF   = 8'h0C;
    localparam logic [7:0] CTL_LF   = 8'h0A;
    localparam logic [7:0] CTL_CR   = 8'h0D;
    localparam logic [7:0] CTL_TAB  = 8'h09;

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef struct packed {
        jsu_mode_t   mode;
        logic [2:0]  dc;
        logic [15:0] code;
        logic [15:0] high;
    } jsu_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       quote;
    } jsu_res_t;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            hex_val = 5'd0;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                d = b - 8'h30;
                hex_val = {1'b1, d[3:0]};
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                d = b - 8'h57;
                hex_val = {1'b1, d[3:0]};
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                d = b - 8'h37;
                hex_val = {1'b1, d[3:0]};
            end
        end
    endfunction

endpackage

[hw/rtl/jsu_in_if.sv]
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

[hw/rtl/jsu_out_if.sv]
`timescale 1ns / 1ps

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       string_done;
    logic       closed_by_quote;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output string_done, output closed_by_quote, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last,
                  input string_done, input closed_by_quote, output ready);
endinterface

[hw/rtl/jsu_decode.sv]
`timescale 1ns / 1ps

module jsu_decode (
    input  jsu_pkg::jsu_state_t                    st,
    input  logic [2:0][7:0]                        seen,
    input  logic [7:0]                             in_byte,
    input  logic                                   text_end,
    output jsu_pkg::jsu_state_t                    nxt,
    output logic [2:0][7:0]                        seen_nxt,
    output jsu_pkg::jsu_res_t [jsu_pkg::MAX_RES-1:0] res,
    output logic [jsu_pkg::CNT_W-1:0]              cnt
);
    import jsu_pkg::*;

    localparam int IDX_W = $clog2(MAX_RES);

    logic [4:0]       hv;
    logic [15:0]      cv_new;
    logic [20:0]      cp_pair;
    logic [2:0][7:0]  hi_b;
    logic [2:0][7:0]  u_b;
    logic [1:0]       u_len;
    logic [CNT_W-1:0] n;
    logic             do_flush;
    logic             do_hi;
    logic             plain_path;
    logic             esc_path;
    logic             digit_path;

    assign hv     = hex_val(in_byte);
    assign cv_new = {st.code[11:0], hv[3:0]};

    assign hi_b[0] = {4'b1110, st.high[15:12]};
    assign hi_b[1] = {2'b10, st.high[11:6]};
    assign hi_b[2] = {2'b10, st.high[5:0]};

    assign cp_pair = SUPP_BASE + {1'b0, st.high[9:0], cv_new[9:0]};

    always_comb
    begin
        u_b = '0;
        if (cv_new < 16'h0080)
        begin
            u_len = 2'd1;
            u_b[0] = cv_new[7:0];
        end
        else if (cv_new < 16'h0800)
        begin
            u_len = 2'd2;
            u_b[0] = {3'b110, cv_new[10:6]};
            u_b[1] = {2'b10, cv_new[5:0]};
        end
        else
        begin
            u_len = 2'd3;
            u_b[0] = {4'b1110, cv_new[15:12]};
            u_b[1] = {2'b10, cv_new[11:6]};
            u_b[2] = {2'b10, cv_new[5:0]};
        end
    end

    always_comb
    begin
        nxt = st;
        seen_nxt = seen;
        res = '0;
        n = '0;
        do_hi = 1'b0;
        do_flush = 1'b0;
        plain_path = 1'b0;
        esc_path = 1'b0;
        digit_path = 1'b0;

        if (text_end)
        begin
            case (st.mode)
                M_HEX:    do_flush = 1'b1;
                M_HIWAIT: do_hi = 1'b1;
                M_HIESC:  do_hi = 1'b1;
                M_HIHEX:
                begin
                    do_hi = 1'b1;
                    do_flush = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            case (st.mode)
                M_ESC: esc_path = 1'b1;
                M_HEX:
                begin
                    if (hv[4])
                    begin
                        digit_path = 1'b1;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        plain_path = 1'b1;
                    end
                end
                M_HIHEX:
                begin
                    if (hv[4])
                    begin
                        digit_path = 1'b1;
                    end
                    else
                    begin
                        do_hi = 1'b1;
                        do_flush = 1'b1;
                        plain_path = 1'b1;
                    end
                end
                M_HIWAIT:
                begin
                    if (in_byte == CH_BSL)
                    begin
                        nxt.mode = M_HIESC;
                    end
                    else
                    begin
                        do_hi = 1'b1;
                        plain_path = 1'b1;
                    end
                end
                M_HIESC:
                begin
                    if (in_byte == CH_LC_U)
                    begin
                        nxt.mode = M_HIHEX;
                        nxt.dc = 3'd0;
                        nxt.code = 16'd0;
                    end
                    else
                    begin
                        do_hi = 1'b1;
                        esc_path = 1'b1;
                    end
                end
                default: plain_path = 1'b1;
            endcase
        end

        // A pending high surrogate goes out first, then any cut-off digits.
        if (do_hi)
        begin
            res[n[IDX_W-1:0]] = '{data: hi_b[0], valid: 1'b1, done: 1'b0, quote: 1'b0};
            n = n + 1'b1;
            res[n[IDX_W-1:0]] = '{data: hi_b[1], valid: 1'b1, done: 1'b0, quote: 1'b0};
            n = n + 1'b1;
            res[n[IDX_W-1:0]] = '{data: hi_b[2], valid: 1'b1, done: 1'b0, quote: 1'b0};
            n = n + 1'b1;
        end
        if (do_flush)
        begin
            res[n[IDX_W-1:0]] = '{data: CH_QMARK, valid: 1'b1, done: 1'b0, quote: 1'b0};
            n = n + 1'b1;
            if (st.dc >= 3'd1)
            begin
                res[n[IDX_W-1:0]] = '{data: seen[0], valid: 1'b1, done: 1'b0, quote: 1'b0};
                n = n + 1'b1;
            end
            if (st.dc >= 3'd2)
            begin
                res[n[IDX_W-1:0]] = '{data: seen[1], valid: 1'b1, done: 1'b0, quote: 1'b0};
                n = n + 1'b1;
            end
            if (st.dc >= 3'd3)
            begin
                res[n[IDX_W-1:0]] = '{data: seen[2], valid: 1'b1, done: 1'b0, quote: 1'b0};
                n = n + 1'b1;
            end
        end

        if (text_end)
        begin
            if (st.mode == M_ESC || st.mode == M_HIESC)
            begin
                res[n[IDX_W-1:0]] = '{data: CH_BSL, valid: 1'b1, done: 1'b0, quote: 1'b0};
                n = n + 1'b1;
            end
            res[n[IDX_W-1:0]] = '{data: 8'd0, valid: 1'b0, done: 1'b1, quote: 1'b0};
            n = n + 1'b1;
            nxt = '{mode: M_PLAIN, dc: 3'd0, code: 16'd0, high: 16'd0};
        end

        if (esc_path)
        begin
            nxt.mode = M_PLAIN;
            case (in_byte)
                CH_LC_B:
                begin
                    res[n[IDX_W-1:0]] = '{data: CTL_BS, valid: 1'b1, done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                end
                CH_LC_F:
                begin
                    res[n[IDX_W-1:0]] = '{data: CTL_FF, valid: 1'b1, done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                end
                CH_LC_N:
                begin
                    res[n[IDX_W-1:0]] = '{data: CTL_LF, valid: 1'b1, done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                end
                CH_LC_R:
                begin
                    res[n[IDX_W-1:0]] = '{data: CTL_CR, valid: 1'b1, done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                end
                CH_LC_T:
                begin
                    res[n[IDX_W-1:0]] = '{data: CTL_TAB, valid: 1'b1, done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                end
                CH_LC_U:
                begin
                    nxt.mode = M_HEX;
                    nxt.dc = 3'd0;
                    nxt.code = 16'd0;
                end
                default:
                begin
                    res[n[IDX_W-1:0]] = '{data: in_byte, valid: 1'b1, done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                end
            endcase
        end

        if (plain_path)
        begin
            nxt.mode = M_PLAIN;
            if (in_byte == CH_BSL)
            begin
                nxt.mode = M_ESC;
            end
            else if (in_byte == CH_QUOTE)
            begin
                res[n[IDX_W-1:0]] = '{data: 8'd0, valid: 1'b0, done: 1'b1, quote: 1'b1};
                n = n + 1'b1;
                nxt = '{mode: M_PLAIN, dc: 3'd0, code: 16'd0, high: 16'd0};
            end
            else
            begin
                res[n[IDX_W-1:0]] = '{data: in_byte, valid: 1'b1, done: 1'b0, quote: 1'b0};
                n = n + 1'b1;
            end
        end

        if (digit_path)
        begin
            nxt.code = cv_new;
            if (st.dc < 3'd3)
            begin
                seen_nxt[st.dc[1:0]] = in_byte;
                nxt.dc = st.dc + 3'd1;
            end
            else
            begin
                nxt.dc = 3'd0;
                if (st.mode == M_HIHEX && cv_new[15:10] == SURR_LOW_TAG)
                begin
                    res[n[IDX_W-1:0]] = '{data: {5'b11110, cp_pair[20:18]}, valid: 1'b1,
                                          done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                    res[n[IDX_W-1:0]] = '{data: {2'b10, cp_pair[17:12]}, valid: 1'b1,
                                          done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                    res[n[IDX_W-1:0]] = '{data: {2'b10, cp_pair[11:6]}, valid: 1'b1,
                                          done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                    res[n[IDX_W-1:0]] = '{data: {2'b10, cp_pair[5:0]}, valid: 1'b1,
                                          done: 1'b0, quote: 1'b0};
                    n = n + 1'b1;
                    nxt.mode = M_PLAIN;
                end
                else
                begin
                    if (st.mode == M_HIHEX)
                    begin
                        res[n[IDX_W-1:0]] = '{data: hi_b[0], valid: 1'b1, done: 1'b0,
                                              quote: 1'b0};
                        n = n + 1'b1;
                        res[n[IDX_W-1:0]] = '{data: hi_b[1], valid: 1'b1, done: 1'b0,
                                              quote: 1'b0};
                        n = n + 1'b1;
                        res[n[IDX_W-1:0]] = '{data: hi_b[2], valid: 1'b1, done: 1'b0,
                                              quote: 1'b0};
                        n = n + 1'b1;
                    end
                    if (cv_new[15:10] == SURR_HIGH_TAG)
                    begin
                        nxt.high = cv_new;
                        nxt.mode = M_HIWAIT;
                    end
                    else
                    begin
                        nxt.mode = M_PLAIN;
                        res[n[IDX_W-1:0]] = '{data: u_b[0], valid: 1'b1, done: 1'b0,
                                              quote: 1'b0};
                        n = n + 1'b1;
                        if (u_len >= 2'd2)
                        begin
                            res[n[IDX_W-1:0]] = '{data: u_b[1], valid: 1'b1, done: 1'b0,
                                                  quote: 1'b0};
                            n = n + 1'b1;
                        end
                        if (u_len == 2'd3)
                        begin
                            res[n[IDX_W-1:0]] = '{data: u_b[2], valid: 1'b1, done: 1'b0,
                                                  quote: 1'b0};
                            n = n + 1'b1;
                        end
                    end
                end
            end
        end

        cnt = n;
    end

endmodule

[hw/rtl/json_string_unescape.sv]
`timescale 1ns / 1ps
// Latency: the first result of a request is offered in the cycle after it is accepted.
// Throughput: results leave the output register one per cycle while tx.ready is high;
// a request yielding one result (a plain byte) passes every cycle while tx.ready holds.
// The next request is taken while the final result of the previous one is handed over.
// Reset (rst_n, asynchronous, active low) empties the result register and returns the
// decoder to plain text; the buffer of seen hex digits is not reset.

module json_string_unescape (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    rx,
    jsu_out_if.source tx
);
    import jsu_pkg::*;

    jsu_state_t                 st_reg;
    jsu_state_t                 st_next;
    logic [2:0][7:0]            seen_reg;
    logic [2:0][7:0]            seen_next;
    jsu_res_t [MAX_RES-1:0]     list_reg;
    jsu_res_t [MAX_RES-1:0]     list_next;
    jsu_res_t [MAX_RES-1:0]     dec_list;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [CNT_W-1:0]           dec_cnt;
    logic                       in_fire;
    logic                       out_fire;

    jsu_decode u_decode (
        .st       (st_reg),
        .seen     (seen_reg),
        .in_byte  (rx.in_byte),
        .text_end (rx.text_end),
        .nxt      (st_next),
        .seen_nxt (seen_next),
        .res      (dec_list),
        .cnt      (dec_cnt)
    );

    assign rx.ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && tx.ready);
    assign in_fire  = rx.valid && rx.ready;
    assign out_fire = tx.valid && tx.ready;

    assign tx.valid           = (cnt_reg != '0);
    assign tx.out_byte        = list_reg[0].data;
    assign tx.byte_valid      = list_reg[0].valid;
    assign tx.last            = (cnt_reg == CNT_W'(1));
    assign tx.string_done     = list_reg[0].done;
    assign tx.closed_by_quote = list_reg[0].quote;

    always_comb
    begin
        list_next = list_reg;
        cnt_next = cnt_reg;
        if (out_fire)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                list_next[i] = list_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
        if (in_fire)
        begin
            list_next = dec_list;
            cnt_next = dec_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{mode: M_PLAIN, dc: 3'd0, code: 16'd0, high: 16'd0};
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
        if (in_fire)
        begin
            seen_reg <= seen_next;
        end
    end

endmodule
